[design/gbs_pkg.sv]
// Package for greedy box suppression: shared types, widths and state codes.
// Used by gbs_ctrl, gbs_datapath and the top level.
package gbs_pkg;

  localparam int COORD_W = 20;
  localparam int THR_W   = 16;
  localparam int LIM_W   = 10;
  localparam int IDX_W   = 12;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ADD_ONE   = 2'd1;
  localparam logic [1:0] REG_MAX_KEPT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DECIDE,
    ST_OUT
  } gbs_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_box;
    logic rd_en;
    logic cmp_en;
    logic clr_hit;
    logic commit;
  } gbs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic cmp_valid;
  } gbs_sts_t;

endpackage

[design/gbs_datapath.sv]
// Datapath for greedy box suppression: kept-box store and pipelined IoU test.
// Depends on gbs_pkg.
module gbs_datapath
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT        = 512,
  parameter int COORD_FRAC_BITS = 4,
  parameter int KW              = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gbs_cmd_t                  cmd,
  output gbs_sts_t                  sts,
  input  logic [KW-1:0]             rd_addr,
  input  logic [KW-1:0]             wr_addr,
  input  logic signed [COORD_W-1:0] in_left,
  input  logic signed [COORD_W-1:0] in_top,
  input  logic signed [COORD_W-1:0] in_right,
  input  logic signed [COORD_W-1:0] in_bottom,
  input  logic [THR_W-1:0]          thr,
  input  logic                      add_one
);

  localparam int DW = COORD_W + 2;   // differences with extension
  localparam int PW = 2 * DW;        // products
  localparam int UW = PW + 2;        // union
  localparam int CW = UW + THR_W + 1;

  logic signed [COORD_W-1:0] mem_l [MAX_KEPT];
  logic signed [COORD_W-1:0] mem_t [MAX_KEPT];
  logic signed [COORD_W-1:0] mem_r [MAX_KEPT];
  logic signed [COORD_W-1:0] mem_b [MAX_KEPT];

  logic signed [COORD_W-1:0] bl_r, bt_r, br_r, bb_r;
  logic signed [COORD_W-1:0] kl_r, kt_r, kr_r, kb_r;
  logic                      s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                      hit_r;

  // stage 2 registers
  logic signed [DW-1:0] iw_r, ih_r, kw_r, kh_r, bw_r, bh_r;
  logic                 ovl_r;
  // stage 3 registers
  logic signed [PW-1:0] inter_r, ak_r, ab_r;
  logic                 ovl3_r;
  // stage 4 registers
  logic signed [CW-1:0] lhs_r, rhs_r;
  logic                 pos_r, ovl4_r;

  logic signed [DW-1:0] e;
  logic signed [DW-1:0] mn_x, mx_x, mn_y, mx_y, iw_raw, ih_raw;
  logic signed [UW-1:0] uni;

  always_ff @(posedge clk) begin
    if (cmd.load_box) begin
      bl_r <= in_left;
      bt_r <= in_top;
      br_r <= in_right;
      bb_r <= in_bottom;
    end
    if (cmd.commit) begin
      mem_l[wr_addr] <= bl_r;
      mem_t[wr_addr] <= bt_r;
      mem_r[wr_addr] <= br_r;
      mem_b[wr_addr] <= bb_r;
    end
    if (cmd.rd_en) begin
      kl_r <= mem_l[rd_addr];
      kt_r <= mem_t[rd_addr];
      kr_r <= mem_r[rd_addr];
      kb_r <= mem_b[rd_addr];
    end
  end

  assign e = add_one ? DW'(1 << COORD_FRAC_BITS) : '0;

  always_comb begin
    mn_x   = (kr_r < br_r) ? DW'(kr_r) : DW'(br_r);
    mx_x   = (kl_r > bl_r) ? DW'(kl_r) : DW'(bl_r);
    mn_y   = (kb_r < bb_r) ? DW'(kb_r) : DW'(bb_r);
    mx_y   = (kt_r > bt_r) ? DW'(kt_r) : DW'(bt_r);
    iw_raw = mn_x - mx_x + e;
    ih_raw = mn_y - mx_y + e;
  end

  always_ff @(posedge clk) begin
    ovl_r <= (kl_r <= br_r) && (kt_r <= bb_r) && (bl_r <= kr_r) && (bt_r <= kb_r);
    iw_r  <= (iw_raw < 0) ? '0 : iw_raw;
    ih_r  <= (ih_raw < 0) ? '0 : ih_raw;
    kw_r  <= DW'(kr_r) - DW'(kl_r) + e;
    kh_r  <= DW'(kb_r) - DW'(kt_r) + e;
    bw_r  <= DW'(br_r) - DW'(bl_r) + e;
    bh_r  <= DW'(bb_r) - DW'(bt_r) + e;
    ovl3_r  <= ovl_r;
    inter_r <= iw_r * ih_r;
    ak_r    <= kw_r * kh_r;
    ab_r    <= bw_r * bh_r;
  end

  assign uni = UW'(ak_r) + UW'(ab_r) - UW'(inter_r);

  always_ff @(posedge clk) begin
    ovl4_r <= ovl3_r;
    pos_r  <= (uni > 0);
    lhs_r  <= CW'(inter_r) <<< 16;
    rhs_r  <= $signed({1'b0, thr}) * CW'(uni);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      s1_v_r <= cmd.cmp_en;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (cmd.clr_hit) begin
        hit_r <= 1'b0;
      end else if (s4_v_r && ovl4_r && pos_r && (lhs_r > rhs_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign sts.hit       = hit_r;
  assign sts.cmp_valid = s4_v_r;

endmodule

[design/gbs_ctrl.sv]
// Controller for greedy box suppression: sequences store reads, decides keep.
// Depends on gbs_pkg.
module gbs_ctrl
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT  = 512,
  parameter int MAX_BOXES = 4096,
  parameter int KW        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  parameter int CNTW      = $clog2(MAX_KEPT + 1),
  parameter int PW        = $clog2(MAX_BOXES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_last_box,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kept,
  output logic [IDX_W-1:0] out_box_index,
  output logic [LIM_W-1:0] out_kept_count,
  output logic             out_list_full,
  output logic             out_list_end,
  input  logic [LIM_W-1:0] max_kept,
  output gbs_cmd_t         cmd,
  input  gbs_sts_t         sts,
  output logic [KW-1:0]    rd_addr,
  output logic [KW-1:0]    wr_addr
);

  localparam int LW = (CNTW > LIM_W) ? CNTW : LIM_W;

  gbs_state_t state_r, state_nxt;
  logic [CNTW-1:0] total_r, total_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [CNTW-1:0] rd_r, rd_nxt;
  logic [CNTW-1:0] done_r, done_nxt;
  logic            last_r, last_nxt;
  logic            kept_r, kept_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LIM_W-1:0] cnt_r, cnt_nxt;
  logic            full_r, full_nxt;
  logic [LW-1:0]   limit;
  logic            room;
  logic            keep;

  assign limit = (LW'(max_kept) > LW'(MAX_KEPT)) ? LW'(MAX_KEPT) : LW'(max_kept);
  assign room  = LW'(total_r) < limit;
  assign keep  = room && !sts.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      pos_r   <= '0;
      rd_r    <= '0;
      done_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      rd_r    <= rd_nxt;
      done_r  <= done_nxt;
      last_r  <= last_nxt;
    end
    kept_r <= kept_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    full_r <= full_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    rd_nxt    = rd_r;
    done_nxt  = done_r;
    last_nxt  = last_r;
    kept_nxt  = kept_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_box = 1'b1;
          cmd.clr_hit  = 1'b1;
          last_nxt     = in_last_box;
          rd_nxt       = '0;
          done_nxt     = '0;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        // skip the scan when the list is full or empty
        if (!room || total_r == '0) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // issue one read per cycle while entries remain and no hit is seen; results return on cmp_valid
        if (rd_r < total_r && !sts.hit) begin
          cmd.rd_en  = 1'b1;
          cmd.cmp_en = 1'b1;
          rd_nxt     = rd_r + 1'b1;
        end
        if (sts.cmp_valid) begin
          done_nxt = done_r + 1'b1;
        end
        if (sts.hit && !sts.cmp_valid && rd_r == done_r) begin
          state_nxt = ST_DECIDE;
        end else if (done_nxt == rd_nxt && (rd_nxt == total_r || sts.hit)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        kept_nxt = keep;
        idx_nxt  = IDX_W'(pos_r);
        cnt_nxt  = LIM_W'(total_r + CNTW'(keep));
        full_nxt = LW'(total_r + CNTW'(keep)) >= limit;
        if (keep) begin
          cmd.commit = 1'b1;
          total_nxt  = total_r + 1'b1;
        end
        if (last_r) begin
          total_nxt = '0;
          pos_nxt   = '0;
        end else if (pos_r == PW'(MAX_BOXES - 1)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_addr        = KW'(rd_r);
  assign wr_addr        = KW'(total_r);
  assign out_kept       = kept_r;
  assign out_box_index  = idx_r;
  assign out_kept_count = cnt_r;
  assign out_list_full  = full_r;
  assign out_list_end   = last_r;

endmodule

[design/greedy_box_suppression.sv]
// Greedy IoU box suppression, one box at a time. The box is tested against the
// boxes kept so far in the list (one stored box read per cycle, then a four-stage
// compare pipeline); a hit ends the scan early, and an empty or full list skips it.
// A new box is taken only after the previous result has been accepted. Synchronous
// active-low reset clears counters and loads register defaults, not the memory.
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT        = 512,
  parameter int MAX_BOXES       = 4096,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_left,
  input  logic signed [COORD_W-1:0] in_top,
  input  logic signed [COORD_W-1:0] in_right,
  input  logic signed [COORD_W-1:0] in_bottom,
  input  logic                      in_last_box,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kept,
  output logic [IDX_W-1:0]          out_box_index,
  output logic [LIM_W-1:0]          out_kept_count,
  output logic                      out_list_full,
  output logic                      out_list_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [THR_W-1:0]          cfg_data
);

  localparam int KW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  logic [THR_W-1:0] thr_r;
  logic             add_one_r;
  logic [LIM_W-1:0] max_kept_r;
  gbs_cmd_t         cmd;
  gbs_sts_t         sts;
  logic [KW-1:0]    rd_addr, wr_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_W'(45875);
      add_one_r  <= 1'b1;
      max_kept_r <= LIM_W'(300);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r      <= cfg_data;
        REG_ADD_ONE:   add_one_r  <= cfg_data[0];
        REG_MAX_KEPT:  max_kept_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  gbs_ctrl #(
    .MAX_KEPT  (MAX_KEPT),
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last_box,
    .out_valid, .out_stall, .out_kept, .out_box_index, .out_kept_count,
    .out_list_full, .out_list_end,
    .max_kept (max_kept_r),
    .cmd, .sts, .rd_addr, .wr_addr
  );

  gbs_datapath #(
    .MAX_KEPT        (MAX_KEPT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .rd_addr, .wr_addr,
    .in_left, .in_top, .in_right, .in_bottom,
    .thr     (thr_r),
    .add_one (add_one_r)
  );

`ifndef SYNTHESIS
  // a stored box is always reported as kept
  a_keep_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_kept) else $error("commit without keep");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kept_count))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
`endif

endmodule
